### hdl/sha1md_pkg.sv
package sha1md_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned ChainN   = 5;
	localparam int unsigned WindowN  = 16;
	localparam int unsigned RoundN   = 80;
	localparam int unsigned FillW    = 7;
	localparam int unsigned LenW     = 64;
	localparam int unsigned IdxW     = 3;

	localparam logic [FillW-1:0] FillLast   = 7'd63;
	localparam logic [FillW-1:0] FillLenPos = 7'd56;
	localparam logic [6:0]       RoundLast  = 7'(RoundN - 1);
	localparam logic [IdxW-1:0]  IdxLast    = 3'd4;
	localparam logic [7:0]       PadMark    = 8'h80;

	localparam logic [WordW-1:0] InitChain [ChainN] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      push;
		byte_src_t src;
		logic      round;
		logic      update;
		logic      out_next;
		logic      clear;
	} dp_cmd_t;

	typedef struct packed {
		logic [FillW-1:0] fill;
		logic             round_last;
		logic             out_last;
	} dp_status_t;

	function automatic logic [WordW-1:0] round_const(input logic [1:0] stage);
		logic [WordW-1:0] k;
		case (stage)
			2'd0:    k = 32'h5a827999;
			2'd1:    k = 32'h6ed9eba1;
			2'd2:    k = 32'h8f1bbcdc;
			default: k = 32'hca62c1d6;
		endcase
		return k;
	endfunction

endpackage

### hdl/sha1md_ctrl.sv
module sha1md_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   byte_present,
	input  logic                   message_end,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sha1md_pkg::dp_cmd_t    cmd,
	input  sha1md_pkg::dp_status_t status
);
	import sha1md_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        ending_q;
	logic        mark_q;
	logic        len_q;
	logic        final_q;
	logic        in_acc;
	logic        out_acc;
	logic        pad_push;
	logic        at_last;

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign out_acc  = (state_q == ST_OUT) && !out_stall;
	assign at_last  = (status.fill == FillLast);
	// A padding cycle pushes a byte unless it is the one that opens the length phase.
	assign pad_push = !mark_q || len_q || (status.fill != FillLenPos);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (byte_present && at_last) begin
						state_nxt = ST_ROUND;
					end else if (message_end) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				if (status.round_last) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (final_q) begin
					state_nxt = ST_OUT;
				end else if (ending_q) begin
					state_nxt = ST_PAD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (pad_push && at_last) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_OUT: begin
				if (out_acc && status.out_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.src   = SRC_MSG;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.push = in_acc && byte_present;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_PAD: begin
				cmd.push = pad_push;
				if (!mark_q) begin
					cmd.src = SRC_MARK;
				end else if (len_q) begin
					cmd.src = SRC_LEN;
				end else begin
					cmd.src = SRC_ZERO;
				end
			end
			ST_OUT: begin
				out_valid    = 1'b1;
				// The last word clears the datapath instead of advancing the index.
				cmd.out_next = out_acc && !status.out_last;
				cmd.clear    = out_acc && status.out_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ending_q <= 1'b0;
			mark_q   <= 1'b0;
			len_q    <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				ending_q <= message_end;
			end
			if (state_q == ST_PAD) begin
				if (!mark_q) begin
					mark_q <= 1'b1;
				end else if (!len_q && (status.fill == FillLenPos)) begin
					len_q <= 1'b1;
				end else if (len_q && at_last) begin
					final_q <= 1'b1;
				end
			end
			if (out_acc && status.out_last) begin
				ending_q <= 1'b0;
				mark_q   <= 1'b0;
				len_q    <= 1'b0;
				final_q  <= 1'b0;
			end
		end
	end

endmodule

### hdl/sha1md_dp.sv
module sha1md_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             message_byte,
	input  sha1md_pkg::dp_cmd_t    cmd,
	output sha1md_pkg::dp_status_t status,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_index,
	output logic                   final_word
);
	import sha1md_pkg::*;

	logic [WordW-1:0] sw_q [WindowN];
	logic [WordW-1:0] chain_q [ChainN];
	logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [FillW-1:0] fill_q;
	logic [LenW-1:0]  bitlen_q;
	logic [6:0]       round_q;
	logic [IdxW-1:0]  out_idx_q;

	logic [7:0]       push_byte;
	logic [LenW-1:0]  len_shifted;
	logic [5:0]       len_shamt;
	logic [WordW-1:0] va, vb, vc, vd, ve;
	logic [WordW-1:0] sched_x, sched_new, wt, fn, tmp;
	logic [1:0]       stage;

	// Length bytes go out most significant first while fill runs from 56 to 63.
	assign len_shamt   = {3'd7 - fill_q[2:0], 3'b000};
	assign len_shifted = bitlen_q >> len_shamt;

	always_comb begin
		case (cmd.src)
			SRC_MSG:  push_byte = message_byte;
			SRC_MARK: push_byte = PadMark;
			SRC_ZERO: push_byte = 8'h00;
			SRC_LEN:  push_byte = len_shifted[7:0];
			default:  push_byte = 8'h00;
		endcase
	end

	// The first round takes its working variables straight from the chain.
	always_comb begin
		if (round_q == 7'd0) begin
			va = chain_q[0];
			vb = chain_q[1];
			vc = chain_q[2];
			vd = chain_q[3];
			ve = chain_q[4];
		end else begin
			va = a_q;
			vb = b_q;
			vc = c_q;
			vd = d_q;
			ve = e_q;
		end
	end

	always_comb begin
		case (round_q) inside
			[7'd0:7'd19]:  stage = 2'd0;
			[7'd20:7'd39]: stage = 2'd1;
			[7'd40:7'd59]: stage = 2'd2;
			default:       stage = 2'd3;
		endcase
	end

	always_comb begin
		case (stage)
			2'd0:    fn = (vb & vc) | (~vb & vd);
			2'd2:    fn = (vb & vc) | (vb & vd) | (vc & vd);
			default: fn = vb ^ vc ^ vd;
		endcase
	end

	assign sched_x   = sw_q[13] ^ sw_q[8] ^ sw_q[2] ^ sw_q[0];
	assign sched_new = {sched_x[30:0], sched_x[31]};
	assign wt        = (round_q < 7'd16) ? sw_q[0] : sched_new;
	assign tmp       = {va[26:0], va[31:27]} + fn + ve + round_const(stage) + wt;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < WindowN - 1; i++) begin
				sw_q[i] <= {sw_q[i][23:0], sw_q[i+1][31:24]};
			end
			sw_q[WindowN-1] <= {sw_q[WindowN-1][23:0], push_byte};
		end else if (cmd.round) begin
			for (int i = 0; i < WindowN - 1; i++) begin
				sw_q[i] <= sw_q[i+1];
			end
			sw_q[WindowN-1] <= wt;
		end
		if (cmd.round) begin
			a_q <= tmp;
			b_q <= va;
			c_q <= {vb[1:0], vb[31:2]};
			d_q <= vc;
			e_q <= vd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ChainN; i++) begin
				chain_q[i] <= InitChain[i];
			end
			fill_q    <= '0;
			bitlen_q  <= '0;
			round_q   <= '0;
			out_idx_q <= '0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 7'd1;
				if (cmd.src == SRC_MSG) begin
					bitlen_q <= bitlen_q + 64'd8;
				end
			end
			if (cmd.round) begin
				round_q <= round_q + 7'd1;
			end
			if (cmd.update) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				fill_q     <= '0;
				round_q    <= '0;
			end
			if (cmd.out_next) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
			if (cmd.clear) begin
				for (int i = 0; i < ChainN; i++) begin
					chain_q[i] <= InitChain[i];
				end
				fill_q    <= '0;
				bitlen_q  <= '0;
				out_idx_q <= '0;
			end
		end
	end

	assign status.fill       = fill_q;
	assign status.round_last = (round_q == RoundLast);
	assign status.out_last   = (out_idx_q == IdxLast);

	assign digest_word = chain_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign final_word  = (out_idx_q == IdxLast);

endmodule

### hdl/sha1_message_digest_core.sv
// SHA-1 hasher that takes one message byte per input transaction and returns the
// 160-bit digest as five 32-bit output transactions, h0 first, with final_word set
// on the fifth. A transaction with message_end set closes the message; if its
// byte_present is clear it carries no byte, so an empty message is hashed too.
// A transaction with neither byte_present nor message_end changes nothing.
// Operation: the block works on one transaction at a time and holds in_stall high
// while it is busy. The byte that fills a 64-byte block starts 80 rounds of the
// single shared round unit, one per cycle, followed by a step that folds the
// result into the chaining words. Closing a message pushes the padding one byte
// per cycle (the 0x80 mark, zeros up to byte 56, a step without a push that
// switches to the length, then eight length bytes), with the rounds and the fold
// for each padded block, and then the five digest words, one per cycle that
// out_stall allows. After the fifth word is taken, the chaining words, the
// counters and the control flags return to their initial values, and the next
// message can start.
module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);
	import sha1md_pkg::*;

	// Commands from the controller and status back from the datapath.
	dp_cmd_t    cmd;
	dp_status_t status;

	sha1md_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_present (byte_present),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status)
	);

	// The datapath holds the block window, the working variables and the chain.
	sha1md_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.message_byte (message_byte),
		.cmd          (cmd),
		.status       (status),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.final_word   (final_word)
	);

endmodule

### verif/tb_sha1_message_digest_core.sv
`timescale 1ns / 100ps

// Self-checking testbench for the streaming SHA-1 core.
//
// Message bytes go in as input transactions. Each digest comes back as five output
// transactions, h0 first. A behavioral SHA-1 model inside this module follows every
// accepted input transaction. It queues the five digest words that a closing
// transaction must produce, and a checker compares each accepted output transaction
// with the oldest queued word, one field at a time.
//
// The run has two parts. A short directed table comes first: the empty message, the
// classic three-byte message closed in both ways, ignored transactions, single
// bytes at the extremes, and back-to-back closes. Rows whose digest is well known
// carry that digest and are checked against it. The other rows are checked against
// the model. Random messages follow. Most are short, and some have lengths around
// the padding spill point, around one full block and around the spill point of the
// second block. Both sides insert random idle gaps, mostly short with a few long
// ones, and there are stretches with no gaps at all. The sender also waits now and
// then until every queued digest word has come back.
module tb_sha1_message_digest_core;

	import sha1md_pkg::*;

	localparam int unsigned ItemTarget = 330;
	localparam int unsigned StallLimit = 3000;
	localparam int unsigned DrainTail  = 100;
	localparam int unsigned DirRowsN   = 19;

	// SHA-1 round constants and initial hash words.
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [159:0] InitDigest = 160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
	localparam logic [7:0]   PadByte    = 8'h80;
	localparam int unsigned  LenOffset  = 56;

	// Digests that are standard test vectors.
	localparam logic [159:0] DigestEmpty = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] DigestAbc   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         last;
		logic         known;
		logic [159:0] golden;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  message_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        message_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	sha1_message_digest_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_byte (message_byte),
		.byte_present (byte_present),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.final_word   (final_word)
	);

	always #5 clk = ~clk;

	// The SHA-1 model's state, which follows the core's chaining words, block buffer
	// and length counter.
	logic [31:0] sha_chain [5];
	logic [7:0]  sha_block [64];
	int unsigned sha_fill;
	logic [63:0] sha_bit_count;

	// Digest words that are still to come, oldest first.
	digest_beat_t pending_digest_words [$];

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_hold = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;
	bit          hold_for_drain = 1'b0;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
		return (x << s) | (x >> (32 - s));
	endfunction

	task automatic sha_restart();
		for (int i = 0; i < 5; i++) begin
			sha_chain[i] = InitDigest[159 - 32 * i -: 32];
		end
		for (int i = 0; i < 64; i++) begin
			sha_block[i] = 8'h00;
		end
		sha_fill = 0;
		sha_bit_count = '0;
	endtask

	// One 80-round compression of the 64-byte block into the chaining words. The
	// message schedule rolls through a 16-word window.
	task automatic sha_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {sha_block[4 * i], sha_block[4 * i + 1], sha_block[4 * i + 2],
				sha_block[4 * i + 3]};
		end
		a = sha_chain[0];
		b = sha_chain[1];
		c = sha_chain[2];
		d = sha_chain[3];
		e = sha_chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^
					w[r % 16], 1);
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		sha_chain[0] += a;
		sha_chain[1] += b;
		sha_chain[2] += c;
		sha_chain[3] += d;
		sha_chain[4] += e;
	endtask

	task automatic sha_absorb(input logic [7:0] v);
		sha_block[sha_fill] = v;
		sha_fill++;
		if (sha_fill == 64) begin
			sha_compress();
			sha_fill = 0;
		end
	endtask

	// Follows one accepted input transaction. When it closes the message, the
	// padding is applied and the finished digest is returned.
	task automatic sha_take(input logic [7:0] v, input logic present, input logic last,
			output bit done, output logic [159:0] digest);
		logic [63:0] total;
		done = 1'b0;
		digest = '0;
		if (present) begin
			sha_absorb(v);
			sha_bit_count += 64'd8;
		end
		if (last) begin
			total = sha_bit_count;
			sha_absorb(PadByte);
			// When the length no longer fits in this block, zero-fill it and start
			// another one.
			if (sha_fill > LenOffset) begin
				while (sha_fill != 0) sha_absorb(8'h00);
			end
			while (sha_fill < LenOffset) sha_absorb(8'h00);
			for (int i = 0; i < 8; i++) begin
				sha_absorb(total[63 - 8 * i -: 8]);
			end
			digest = {sha_chain[0], sha_chain[1], sha_chain[2], sha_chain[3], sha_chain[4]};
			done = 1'b1;
			sha_restart();
		end
	endtask

	task automatic queue_digest(input logic [159:0] digest);
		digest_beat_t beat;
		for (int i = 0; i < ChainN; i++) begin
			beat.word = digest[159 - 32 * i -: 32];
			beat.index = i[2:0];
			beat.last = (beat.index == IdxLast);
			pending_digest_words.push_back(beat);
		end
	endtask

	// Idle gaps on the input side: mostly none or short, a few long, and none at all
	// while a steady stretch is running.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Offers one input transaction and returns once in_stall is low after an edge.
	// in_valid is lowered only when a gap or a drain wait actually follows, so it
	// never gets two assignments in one time step.
	task automatic send_txn(input logic [7:0] v, input logic present, input logic last);
		int unsigned gap;
		bit drain;
		gap = pick_gap();
		drain = hold_for_drain && (pending_digest_words.size() != 0);
		hold_for_drain = 1'b0;
		if (gap > 0 || drain) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && (pending_digest_words.size() != 0)) @(posedge clk);
		end
		in_valid <= 1'b1;
		message_byte <= v;
		byte_present <= present;
		message_end <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (present || last) items_sent++;
	endtask

	// Sends a transaction and lets the model follow it. The model's digest is queued
	// unless the caller supplies a known digest.
	task automatic send_and_track(input logic [7:0] v, input logic present, input logic last,
			input logic known, input logic [159:0] golden);
		bit done;
		logic [159:0] digest;
		send_txn(v, present, last);
		sha_take(v, present, last, done, digest);
		if (done) queue_digest(known ? golden : digest);
	endtask

	// Output side: check each accepted transaction, then choose the stall for the
	// next cycle. Stalls come as short bursts, now and then a long one, and no new
	// ones start during a steady stretch.
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		int unsigned r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_digest_words.size() == 0) begin
				$display("%0t: digest word %h (index %0d) arrived with none expected",
					$time, digest_word, word_index);
				error_count++;
			end else begin
				exp_beat = pending_digest_words.pop_front();
				if (digest_word !== exp_beat.word) begin
					$display("%0t: digest_word expected %h, actual %h",
						$time, exp_beat.word, digest_word);
					error_count++;
				end
				if (word_index !== exp_beat.index) begin
					$display("%0t: word_index expected %0d, actual %0d",
						$time, exp_beat.index, word_index);
					error_count++;
				end
				if (final_word !== exp_beat.last) begin
					$display("%0t: final_word expected %b, actual %b",
						$time, exp_beat.last, final_word);
					error_count++;
				end
			end
		end
		r = $urandom_range(0, 99);
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_stall <= 1'b1;
		end else if (rx_steady || r < 70) begin
			out_stall <= 1'b0;
		end else if (r < 95) begin
			out_stall <= 1'b1;
			rx_hold <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b1;
			rx_hold <= $urandom_range(10, 35);
		end
	end

	// The watchdog ends the run when no transaction has been accepted on either side
	// for too long. A close with a padding spill pads and compresses two blocks, and a
	// long output stall can come on top of that, so the limit is set well above both.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t dir_rows [DirRowsN];
		int unsigned msg_len;
		bit end_on_byte;
		bit first_msg;
		logic [7:0] v;

		// The directed table. A row with known set carries the digest that the close
		// must produce. message_byte holds junk on rows without a byte, to show that
		// it is ignored.
		dir_rows = '{
			'{8'h00, 1'b0, 1'b1, 1'b1, DigestEmpty},  // empty message right after reset
			'{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},       // neither byte nor close
			'{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},       // ignored, in mid-message
			'{8'h63, 1'b1, 1'b1, 1'b1, DigestAbc},    // close that carries its byte
			'{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'h63, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'ha5, 1'b0, 1'b1, 1'b1, DigestAbc},    // close without a byte
			'{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},       // single zero byte
			'{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},       // single all-ones byte
			'{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
			'{8'h7f, 1'b1, 1'b1, 1'b0, 160'h0},
			'{8'hff, 1'b0, 1'b1, 1'b1, DigestEmpty},  // empty again, junk byte
			'{8'h55, 1'b1, 1'b1, 1'b0, 160'h0},
			'{8'h00, 1'b0, 1'b1, 1'b1, DigestEmpty}
		};

		sha_restart();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_and_track(dir_rows[i].data, dir_rows[i].present, dir_rows[i].last,
				dir_rows[i].known, dir_rows[i].golden);
		end

		// Random messages. Most are short. Some land around the padding spill point,
		// around one full block, or around the spill point of the second block. Ignored
		// transactions are mixed in as noise, and a message is closed either on its last
		// byte or by a close without a byte.
		first_msg = 1'b1;
		while (items_sent < ItemTarget) begin
			case ($urandom_range(0, 19))
				0: begin
					msg_len = $urandom_range(54, 57);
				end
				1: begin
					msg_len = $urandom_range(62, 65);
				end
				2: begin
					msg_len = $urandom_range(118, 121);
				end
				default: begin
					msg_len = $urandom_range(0, 14);
				end
			endcase
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			end_on_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < msg_len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_and_track(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'h0);
				end
				v = 8'($urandom_range(0, 255));
				send_and_track(v, 1'b1, end_on_byte && (i == msg_len - 1), 1'b0, 160'h0);
			end
			if (!end_on_byte) begin
				send_and_track(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'h0);
			end
			// Now and then the next message waits until the whole digest has been
			// read out. The message after the first random one always does.
			hold_for_drain = first_msg || ($urandom_range(0, 4) == 0);
			first_msg = 1'b0;
		end
		in_valid <= 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		while (pending_digest_words.size() != 0) @(posedge clk);
		repeat (DrainTail) @(posedge clk);

		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### sim.f
hdl/sha1md_pkg.sv
hdl/sha1md_ctrl.sv
hdl/sha1md_dp.sv
hdl/sha1_message_digest_core.sv
verif/tb_sha1_message_digest_core.sv
